// ===== sv/bdq_pkg.sv =====
// Shared types and codes for the bounded deque.
// Used by bdq_cell and bounded_deque; depends on nothing else.
package bdq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STATUS_W  = 2;

    // operation codes carried in s_tuser
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell, at most one bit set
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic rotate;
    } cell_cmd_t;

endpackage

// ===== sv/bdq_cell.sv =====
// One storage cell of the deque chain: a data word and a valid bit.
// Talks to its left and right neighbors; depends on bdq_pkg.
module bdq_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bdq_pkg::cell_cmd_t          cmd,
    input  logic [bdq_pkg::DATA_W-1:0]  value,
    input  logic [bdq_pkg::DATA_W-1:0]  front_data,
    input  logic [bdq_pkg::DATA_W-1:0]  left_data,
    input  logic                        left_valid,
    input  logic [bdq_pkg::DATA_W-1:0]  right_data,
    input  logic                        right_valid,
    output logic [bdq_pkg::DATA_W-1:0]  data,
    output logic                        valid,
    output logic                        tail
);

    logic [bdq_pkg::DATA_W-1:0] data_reg;
    logic [bdq_pkg::DATA_W-1:0] data_next;
    logic                       valid_reg;
    logic                       valid_next;
    logic                       first_hole;

    assign tail       = valid_reg & ~right_valid;
    assign first_hole = left_valid & ~valid_reg;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.push_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (cmd.push_back)
        begin
            if (first_hole)
            begin
                data_next  = value;
                valid_next = 1'b1;
            end
        end
        else if (cmd.pop_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (cmd.pop_back)
        begin
            if (tail)
                valid_next = 1'b0;
        end
        else if (cmd.rotate)
        begin
            // front word wraps around into the tail cell
            if (valid_reg)
                data_next = tail ? front_data : right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== sv/bounded_deque.sv =====
// Bounded double-ended queue built as a shifting chain of bdq_cell.
// Holds the sequencer, fill count and output register; depends on bdq_pkg, bdq_cell.
//
//  channel | direction | tdata        | tuser       | tlast
//  s_*     | in        | value[31:0]  | func[2:0]   | -
//  m_*     | out       | item[31:0]   | status[1:0] | last
//
// Push and pop each give one result; a new request is taken as soon as the
// output register is free or being drained in the same cycle.
// Dump gives one result per held entry: the chain rotates one step per cycle
// and the front cell feeds the output. No request is taken during a dump.
// Reset clears all valid bits and the fill count; cell data is not reset.
// A stall on m_tready holds the result and freezes the dump walk.
module bounded_deque #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bdq_pkg::DATA_W-1:0]    s_tdata,   // value
    input  logic [bdq_pkg::FUNC_W-1:0]    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bdq_pkg::DATA_W-1:0]    m_tdata,   // item
    output logic [bdq_pkg::STATUS_W-1:0]  m_tuser,   // status
    output logic                          m_tlast    // last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                          state_reg, state_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [CW-1:0]                 idx_reg, idx_next;
    logic                          ovalid_reg, ovalid_next;
    logic [bdq_pkg::DATA_W-1:0]    item_reg, item_next;
    logic [bdq_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          last_reg, last_next;
    logic                          load;
    logic                          out_free;
    logic                          accept;
    logic                          empty;
    logic                          full;
    bdq_pkg::cell_cmd_t            cmd;

    logic [bdq_pkg::DATA_W-1:0]    cell_data  [DEPTH];
    logic [DEPTH-1:0]              cell_valid;
    logic [DEPTH-1:0]              cell_tail;
    logic [bdq_pkg::DATA_W-1:0]    tail_data;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [bdq_pkg::DATA_W-1:0] l_data, r_data;
            logic                       l_valid, r_valid;
            if (g == 0)
            begin : g_first
                // push front feeds the new word in from the left
                assign l_data  = s_tdata;
                assign l_valid = 1'b1;
            end
            else
            begin : g_mid_l
                assign l_data  = cell_data[g-1];
                assign l_valid = cell_valid[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_end
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign r_data  = cell_data[g+1];
                assign r_valid = cell_valid[g+1];
            end
            bdq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .value       (s_tdata),
                .front_data  (cell_data[0]),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .data        (cell_data[g]),
                .valid       (cell_valid[g]),
                .tail        (cell_tail[g])
            );
        end
    endgenerate

    // at most one cell is the tail, so an OR picks the back word
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
            tail_data = tail_data | (cell_tail[i] ? cell_data[i] : '0);
    end

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_FULL);
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        load        = 1'b0;
        item_next   = '0;
        status_next = bdq_pkg::ST_OK;
        last_next   = 1'b1;

        if (state_reg == ST_DUMP)
        begin
            if (out_free)
            begin
                load       = 1'b1;
                item_next  = cell_data[0];
                cmd.rotate = 1'b1;
                last_next  = (idx_reg == cnt_reg - CNT_ONE);
                idx_next   = idx_reg + CNT_ONE;
                if (last_next)
                    state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            case (s_tuser)
                bdq_pkg::FN_PUSH_BACK, bdq_pkg::FN_PUSH_FRONT:
                begin
                    load = 1'b1;
                    if (full)
                        status_next = bdq_pkg::ST_FULL;
                    else
                    begin
                        cmd.push_back  = (s_tuser == bdq_pkg::FN_PUSH_BACK);
                        cmd.push_front = (s_tuser == bdq_pkg::FN_PUSH_FRONT);
                        cnt_next       = cnt_reg + CNT_ONE;
                    end
                end
                bdq_pkg::FN_DUMP:
                begin
                    load = 1'b1;
                    if (empty)
                        status_next = bdq_pkg::ST_EMPTY;
                    else
                    begin
                        item_next  = cell_data[0];
                        cmd.rotate = 1'b1;
                        last_next  = (cnt_reg == CNT_ONE);
                        idx_next   = CNT_ONE;
                        if (!last_next)
                            state_next = ST_DUMP;
                    end
                end
                bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK:
                begin
                    load = 1'b1;
                    if (empty)
                        status_next = bdq_pkg::ST_EMPTY;
                    else
                    begin
                        cmd.pop_front = (s_tuser == bdq_pkg::FN_POP_FRONT);
                        cmd.pop_back  = (s_tuser == bdq_pkg::FN_POP_BACK);
                        item_next     = cmd.pop_front ? cell_data[0] : tail_data;
                        cnt_next      = cnt_reg - CNT_ONE;
                    end
                end
                default:
                begin
                    // undefined operation: taken, no result
                    load = 1'b0;
                end
            endcase
        end
    end

    assign ovalid_next = load ? 1'b1 : (m_tready ? 1'b0 : ovalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg   <= item_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = item_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == cnt_reg)
        else $error("fill count disagrees with cell valid bits");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("fill count above depth");

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> cell_valid[0] && $onehot(cell_tail))
        else $error("held entries not packed at the front");

    a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (idx_reg != '0) && (idx_reg < cnt_reg))
        else $error("dump walk index out of range");

    a_dump_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) && !out_free |=> $stable(cell_valid) && $stable(idx_reg))
        else $error("dump advanced while output stalled");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for bounded_deque: directed table, then random request phases.
// Depends on bdq_pkg and bounded_deque; results are checked against an in-bench deque mirror.
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH       = bdq_pkg::DEPTH_DEF;
    localparam int DATA_W      = bdq_pkg::DATA_W;
    localparam int FUNC_W      = bdq_pkg::FUNC_W;
    localparam int STATUS_W    = bdq_pkg::STATUS_W;
    localparam int RAND_ITEMS  = 140;
    localparam int HOLD_CYCLES = 400;
    // slowest run: ~230 requests, dumps of up to DEPTH results, each result behind
    // a random stall, plus one long hold-off; taken many times over
    localparam int LIMIT       = 200000;

    typedef struct packed {
        logic signed [DATA_W-1:0]  item;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } result_t;

    typedef struct {
        logic [FUNC_W-1:0]         func;
        logic signed [DATA_W-1:0]  value;
        int                        rep;     // repeat count, value steps by one
        bit                        typed;   // result written in below
        logic signed [DATA_W-1:0]  want_item;
        logic [STATUS_W-1:0]       want_status;
    } plan_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [DATA_W-1:0]           s_tdata = '0;
    logic [FUNC_W-1:0]           s_tuser = '0;
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [DATA_W-1:0]           m_tdata;
    logic [STATUS_W-1:0]         m_tuser;
    logic                        m_tlast;

    // deque mirror
    logic signed [DATA_W-1:0]    mirror [DEPTH];
    int                          mirror_front = 0;
    int                          mirror_fill = 0;
    result_t                     owed [$];

    plan_row_t                   plan [$];
    int                          cycles = 0;
    int                          misses = 0;
    int                          checked = 0;
    int                          n_req = 0;
    int                          n_dump = 0;
    int                          n_full = 0;
    int                          n_empty = 0;
    int                          hold_reqs = 0;
    int                          hold_done = 0;
    int                          hold_left = 0;
    bit                          calm = 1'b0;

    bounded_deque #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // value
        .s_tuser  (s_tuser),   // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // item
        .m_tuser  (m_tuser),   // status
        .m_tlast  (m_tlast)    // last
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, owed.size());
            $display("Verification failed");
            $finish;
        end
    end

    // apply one accepted request to the mirror; queue its results when keep is set
    task automatic mirror_op(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                             input bit keep);
        result_t res [$];
        int      slot;
        n_req++;
        case (f)
            bdq_pkg::FN_PUSH_BACK, bdq_pkg::FN_PUSH_FRONT:
            begin
                if (mirror_fill >= DEPTH)
                begin
                    res.push_back('{'0, bdq_pkg::ST_FULL, 1'b1});
                    n_full++;
                end
                else
                begin
                    if (f == bdq_pkg::FN_PUSH_BACK)
                        slot = (mirror_front + mirror_fill) % DEPTH;
                    else
                    begin
                        mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                        slot = mirror_front;
                    end
                    mirror[slot] = v;
                    mirror_fill++;
                    res.push_back('{'0, bdq_pkg::ST_OK, 1'b1});
                end
            end
            bdq_pkg::FN_DUMP:
            begin
                n_dump++;
                if (mirror_fill == 0)
                begin
                    res.push_back('{'0, bdq_pkg::ST_EMPTY, 1'b1});
                    n_empty++;
                end
                else
                    for (int i = 0; i < mirror_fill; i++)
                        res.push_back('{mirror[(mirror_front + i) % DEPTH], bdq_pkg::ST_OK,
                                        i == mirror_fill - 1});
            end
            bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK:
            begin
                if (mirror_fill == 0)
                begin
                    res.push_back('{'0, bdq_pkg::ST_EMPTY, 1'b1});
                    n_empty++;
                end
                else
                begin
                    if (f == bdq_pkg::FN_POP_FRONT)
                    begin
                        slot = mirror_front;
                        mirror_front = (mirror_front + 1) % DEPTH;
                    end
                    else
                        slot = (mirror_front + mirror_fill - 1) % DEPTH;
                    mirror_fill--;
                    if (mirror_fill == 0)
                        mirror_front = 0;
                    res.push_back('{mirror[slot], bdq_pkg::ST_OK, 1'b1});
                end
            end
            default:
                n_req--;    // unknown codes are dropped by the block
        endcase
        if (keep)
            foreach (res[i])
                owed.push_back(res[i]);
    endtask

    // offer one request and return at the edge where it is accepted
    task automatic offer(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_owed();
        s_tvalid <= 1'b0;
        while (owed.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stalls, a calm stretch, and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_reqs != hold_done)
        begin
            hold_done <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (calm)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 25);
    end

    task automatic flag_miss(input string msg);
        misses++;
        if (misses <= 10)
            $display("cycle %0d: %s", cycles, msg);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (owed.size() == 0)
                flag_miss($sformatf("unexpected result item %h status %0d last %b",
                                    m_tdata, m_tuser, m_tlast));
            else
            begin
                want = owed.pop_front();
                checked++;
                if (m_tdata !== want.item || m_tuser !== want.status || m_tlast !== want.last)
                    flag_miss($sformatf("got item %h status %0d last %b, want %h %0d %b",
                                        m_tdata, m_tuser, m_tlast,
                                        want.item, want.status, want.last));
            end
        end
    end

    initial
    begin
        int                       taken;
        int                       phase;
        int                       len;
        int                       kind;
        logic [FUNC_W-1:0]        f;
        logic signed [DATA_W-1:0] v;

        // func, value, repeat, typed, item, status
        plan.push_back('{bdq_pkg::FN_DUMP,       32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_EMPTY});
        plan.push_back('{bdq_pkg::FN_POP_FRONT,  32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_EMPTY});
        plan.push_back('{bdq_pkg::FN_POP_BACK,   32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_EMPTY});
        plan.push_back('{bdq_pkg::FN_PUSH_BACK,  32'sh7fff_ffff, 1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        // taking the only entry must leave the store empty
        plan.push_back('{bdq_pkg::FN_POP_FRONT,  32'sd0,         1,  1'b1,
                         32'sh7fff_ffff, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_POP_BACK,   32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_EMPTY});
        plan.push_back('{bdq_pkg::FN_PUSH_FRONT, 32'sh8000_0000, 1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_POP_BACK,   32'sd0,         1,  1'b1,
                         32'sh8000_0000, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_DUMP,       32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_EMPTY});
        plan.push_back('{bdq_pkg::FN_PUSH_BACK,  32'sd1,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_PUSH_FRONT, 32'shffff_ffff, 1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_PUSH_BACK,  32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_PUSH_FRONT, 32'sh8000_0000, 1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_DUMP,       32'sd0,         1,  1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_POP_FRONT,  32'sd0,         1,  1'b1,
                         32'sh8000_0000, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_POP_BACK,   32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{3'd5,                   32'sh1234_5678, 1,  1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{3'd6,                   32'sh5555_aaaa, 1,  1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{3'd7,                   32'shffff_ffff, 1,  1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        // fill to the top and run past it
        plan.push_back('{bdq_pkg::FN_PUSH_BACK,  32'sha5a5_0000, 32, 1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_PUSH_FRONT, 32'sh5a5a_5a5a, 1,  1'b1,
                         32'sd0, bdq_pkg::ST_FULL});
        plan.push_back('{bdq_pkg::FN_PUSH_BACK,  32'sd0,         1,  1'b1,
                         32'sd0, bdq_pkg::ST_FULL});
        plan.push_back('{bdq_pkg::FN_DUMP,       32'sd0,         1,  1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_POP_FRONT,  32'sd0,         16, 1'b0,
                         32'sd0, bdq_pkg::ST_OK});
        plan.push_back('{bdq_pkg::FN_POP_BACK,   32'sd0,         17, 1'b0,
                         32'sd0, bdq_pkg::ST_OK});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            for (int k = 0; k < plan[i].rep; k++)
            begin
                offer(plan[i].func, plan[i].value + k);
                mirror_op(plan[i].func, plan[i].value + k, !plan[i].typed);
                if (plan[i].typed)
                    owed.push_back('{plan[i].want_item, plan[i].want_status, 1'b1});
            end
        drain_owed();

        taken = 0;
        phase = 0;
        while (taken < RAND_ITEMS)
        begin
            kind = $urandom_range(0, 3);
            len  = (kind == 0) ? $urandom_range(4, 36) : $urandom_range(3, 20);
            calm = (phase >= 5 && phase <= 8);
            // receiver holds off while this phase keeps requesting
            if (phase == 2)
                hold_reqs++;
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    f = FUNC_W'($urandom_range(5, 7));
                    v = $urandom;
                    offer(f, v);
                    mirror_op(f, v, 1'b1);
                end
                case (kind)
                    0:
                        f = $urandom_range(0, 1) ? bdq_pkg::FN_PUSH_BACK
                                                 : bdq_pkg::FN_PUSH_FRONT;
                    1:
                        f = $urandom_range(0, 1) ? bdq_pkg::FN_POP_FRONT
                                                 : bdq_pkg::FN_POP_BACK;
                    2:
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: f = bdq_pkg::FN_PUSH_BACK;
                            3, 4:    f = bdq_pkg::FN_PUSH_FRONT;
                            5, 6:    f = bdq_pkg::FN_POP_FRONT;
                            7, 8:    f = bdq_pkg::FN_POP_BACK;
                            default: f = bdq_pkg::FN_DUMP;
                        endcase
                    end
                    default: f = FUNC_W'($urandom_range(0, 4));
                endcase
                v = rand_word();
                offer(f, v);
                mirror_op(f, v, 1'b1);
                taken++;
            end
            if ($urandom_range(0, 1))
            begin
                v = $urandom;
                offer(bdq_pkg::FN_DUMP, v);
                mirror_op(bdq_pkg::FN_DUMP, v, 1'b1);
                taken++;
            end
            if (phase == 4 || $urandom_range(0, 3) == 0)
                drain_owed();
            phase++;
        end
        calm = 1'b0;

        drain_owed();
        repeat (50) @(posedge clk);

        $display("covered %0d requests in %0d random phases: %0d dumps, %0d full, %0d empty",
                 n_req, phase, n_dump, n_full, n_empty);
        $display("%0d results checked, %0d mismatches", checked, misses);
        if (misses == 0 && owed.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
